/* rtl/dk3_adpcm_stereo_decoder_unit_defines.svh */
// Assertion macros used by the decoder's back end RTL file.
`ifndef DK3_ADPCM_STEREO_DECODER_UNIT_DEFINES_SVH
`define DK3_ADPCM_STEREO_DECODER_UNIT_DEFINES_SVH

// Condition in a cycle implies a property in the same cycle.
`define DK3_ASSERT_IMPL(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Condition in a cycle implies a property in the following cycle.
`define DK3_ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* rtl/dk3_pkg.sv */
// Shared constants, types and arithmetic functions of the stereo ADPCM decoder.
package dk3_pkg;

   localparam int MAX_BLOCK_BYTES_DEF = 4096;
   localparam int PREAMBLE_BYTES      = 16;
   localparam int RESET_BLOCK_SIZE    = 1024;
   localparam int CSR_W               = 13;
   localparam int INDEX_MAX           = 88;
   localparam int CMD_DEPTH           = 2;
   localparam int OUT_DEPTH           = 2;

   // Work to be done for one nibble.
   localparam logic [1:0] NIB_NONE     = 2'd0;
   localparam logic [1:0] NIB_SUM      = 2'd1;
   localparam logic [1:0] NIB_DIFF     = 2'd2;
   localparam logic [1:0] NIB_SUM_EMIT = 2'd3;

   // Work to be done for one preamble byte.
   localparam logic [2:0] PRE_NONE      = 3'd0;
   localparam logic [2:0] PRE_LATCH_LO  = 3'd1;
   localparam logic [2:0] PRE_LOAD_SUM  = 3'd2;
   localparam logic [2:0] PRE_LOAD_DIFF = 3'd3;
   localparam logic [2:0] PRE_LOAD_SIDX = 3'd4;
   localparam logic [2:0] PRE_LOAD_DIDX = 3'd5;

   localparam logic [14:0] STEP_TABLE [0:INDEX_MAX] = '{
      15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
      15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
      15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
      15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
      15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
      15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
      15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
      15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
      15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
      15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
      15'd29794, 15'd32767
   };

   typedef struct packed {
      logic       is_payload;
      logic [2:0] pre_op;
      logic [7:0] data;
      logic [1:0] op0;
      logic       end0;
      logic [1:0] op1;
      logic       end1;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] sum;
      logic signed [15:0] chan;
      logic               last;
   } pair_type;

   typedef struct packed {
      logic signed [15:0] pred;
      logic [6:0]         idx;
   } adapt_type;

   function automatic logic [6:0] clamp_index(input logic [7:0] b);
      clamp_index = (b > 8'(INDEX_MAX)) ? 7'(INDEX_MAX) : b[6:0];
   endfunction

   // One step update of a predictor and its step index by a nibble.
   function automatic adapt_type adapt(input logic signed [15:0] pred,
                                       input logic [6:0] idx,
                                       input logic [3:0] nib);
      logic [14:0]        step;
      logic [16:0]        delta;
      logic signed [17:0] ext_pred;
      logic signed [17:0] delta_s;
      logic signed [17:0] total;
      logic [7:0]         up;
      adapt_type          r;
      step = (idx > 7'(INDEX_MAX)) ? STEP_TABLE[INDEX_MAX] : STEP_TABLE[idx];
      delta = 17'(step[14:3]);
      if (nib[2]) delta = delta + 17'(step);
      if (nib[1]) delta = delta + 17'(step[14:1]);
      if (nib[0]) delta = delta + 17'(step[14:2]);
      ext_pred = 18'(pred);
      delta_s  = signed'({1'b0, delta});
      total    = nib[3] ? ext_pred - delta_s : ext_pred + delta_s;
      if (total > 18'sd32767) begin
         r.pred = 16'sh7FFF;
      end else if (total < -18'sd32768) begin
         r.pred = 16'sh8000;
      end else begin
         r.pred = total[15:0];
      end
      // Larger nibble magnitudes raise the index by 2, 4, 6 or 8; small ones lower it.
      up = {1'b0, idx} + {5'd0, nib[1:0], 1'b0} + 8'd2;
      if (nib[2]) begin
         r.idx = (up > 8'(INDEX_MAX)) ? 7'(INDEX_MAX) : up[6:0];
      end else begin
         r.idx = (idx == 7'd0) ? 7'd0 : idx - 7'd1;
      end
      adapt = r;
   endfunction

endpackage

/* rtl/dk3_fifo.sv */
// Small register queue used between the front, the back and the result port.
module dk3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/dk3_front.sv */
// Front end: tracks the byte position in the block and classifies each byte.
module dk3_front #(
   parameter int MAX_BLOCK_BYTES = dk3_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [dk3_pkg::CSR_W-1:0]  csr_wr_data,
   input  logic                       byte_valid,
   input  logic [7:0]                 byte_data,
   output logic                       cmd_push,
   output dk3_pkg::cmd_type           cmd_data
);
   import dk3_pkg::*;

   localparam int POS_W      = $clog2(MAX_BLOCK_BYTES);
   localparam int SIZE_W     = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int CMP_W      = (SIZE_W > CSR_W) ? SIZE_W : CSR_W;
   localparam int MIN_SIZE   = PREAMBLE_BYTES + 1;
   localparam int RESET_SIZE = (RESET_BLOCK_SIZE > MAX_BLOCK_BYTES) ?
                               MAX_BLOCK_BYTES : RESET_BLOCK_SIZE;

   localparam logic [1:0] PH_SUM_A = 2'd0;
   localparam logic [1:0] PH_DIFF  = 2'd1;
   localparam logic [1:0] PH_SUM_B = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic       last;
      logic [1:0] phase;
   } nib_type;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]        phase_ff, phase_in;
   logic [SIZE_W:0]   pos_x;
   logic [CMP_W-1:0]  wide;
   logic              is_pre, last, last2;
   nib_type           n0, n1;
   logic [2:0]        pre_op;

   // Walks the sum, difference, sum pattern; a triplet needs three nibbles left.
   function automatic nib_type next_nib(input logic [1:0] ph, input logic skip,
                                        input logic endf);
      nib_type r;
      r.op    = NIB_NONE;
      r.last  = 1'b0;
      r.phase = ph;
      unique case (ph)
         PH_SUM_A: begin
            if (!skip) begin
               r.op    = NIB_SUM;
               r.phase = PH_DIFF;
            end
         end
         PH_DIFF: begin
            r.op    = NIB_DIFF;
            r.phase = PH_SUM_B;
         end
         PH_SUM_B: begin
            r.op    = NIB_SUM_EMIT;
            r.last  = endf;
            r.phase = PH_SUM_A;
         end
         default: begin
            r.phase = PH_SUM_A;
         end
      endcase
      next_nib = r;
   endfunction

   assign pos_x  = (SIZE_W + 1)'(pos_ff);
   assign last   = (pos_x + (SIZE_W + 1)'(1)) == (SIZE_W + 1)'(size_ff);
   assign last2  = (pos_x + (SIZE_W + 1)'(2)) == (SIZE_W + 1)'(size_ff);
   assign is_pre = pos_ff < POS_W'(PREAMBLE_BYTES);
   assign wide   = CMP_W'(csr_wr_data);

   assign n0 = next_nib(phase_ff, last, last);
   assign n1 = next_nib(n0.phase, last, last || last2);

   always_comb begin
      if (wide < CMP_W'(MIN_SIZE)) begin
         size_in = SIZE_W'(MIN_SIZE);
      end else if (wide > CMP_W'(MAX_BLOCK_BYTES)) begin
         size_in = SIZE_W'(MAX_BLOCK_BYTES);
      end else begin
         size_in = wide[SIZE_W-1:0];
      end
   end

   always_comb begin
      unique case (pos_ff[3:0]) inside
         4'd10, 4'd12: pre_op = PRE_LATCH_LO;
         4'd11:        pre_op = PRE_LOAD_SUM;
         4'd13:        pre_op = PRE_LOAD_DIFF;
         4'd14:        pre_op = PRE_LOAD_SIDX;
         4'd15:        pre_op = PRE_LOAD_DIDX;
         default:      pre_op = PRE_NONE;
      endcase
   end

   always_comb begin
      cmd_data.is_payload = !is_pre;
      cmd_data.pre_op     = is_pre ? pre_op : PRE_NONE;
      cmd_data.data       = byte_data;
      cmd_data.op0        = is_pre ? NIB_NONE : n0.op;
      cmd_data.end0       = n0.last;
      cmd_data.op1        = is_pre ? NIB_NONE : n1.op;
      cmd_data.end1       = n1.last;
   end

   assign cmd_push = byte_valid;

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      if (csr_wr_en) begin
         pos_in   = '0;
         phase_in = PH_SUM_A;
      end else if (byte_valid) begin
         if (last) begin
            pos_in   = '0;
            phase_in = PH_SUM_A;
         end else begin
            pos_in   = pos_ff + POS_W'(1);
            phase_in = is_pre ? phase_ff : n1.phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_W'(RESET_SIZE);
         pos_ff   <= '0;
         phase_ff <= PH_SUM_A;
      end else begin
         if (csr_wr_en) begin
            size_ff <= size_in;
         end
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* rtl/dk3_back.sv */
// Back end: runs the predictor updates one nibble per cycle when not stalled and forms stereo pairs.
`include "dk3_adpcm_stereo_decoder_unit_defines.svh"

module dk3_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  dk3_pkg::cmd_type  cmd_data,
   output logic              cmd_pop,
   input  logic              out_full,
   output logic              out_push,
   output dk3_pkg::pair_type out_data
);
   import dk3_pkg::*;

   localparam logic [1:0] S2_LOAD_CHAN = 2'd0;
   localparam logic [1:0] S2_EMIT_DIFF = 2'd1;
   localparam logic [1:0] S2_EMIT_SUM  = 2'd2;

   logic signed [15:0] sum_ff, sum_in;
   logic signed [15:0] diff_ff, diff_in;
   logic [6:0]         sum_idx_ff, sum_idx_in;
   logic [6:0]         diff_idx_ff, diff_idx_in;
   logic [7:0]         lo_ff, lo_in;
   logic               nib_sel_ff, nib_sel_in;
   logic signed [15:0] chan_ff, chan_in;

   logic               s2_valid_ff, s2_valid_in;
   logic [1:0]         s2_op_ff, s2_op_in;
   logic signed [15:0] s2_sum_ff, s2_sum_in;
   logic signed [15:0] s2_val_ff, s2_val_in;
   logic               s2_last_ff, s2_last_in;

   logic               step, s2_emit, s2_go;
   logic [1:0]         cur_op;
   logic               cur_end;
   logic [3:0]         nib;
   adapt_type          res;
   logic signed [16:0] avg_sum, avg_adj;
   logic signed [15:0] avg;

   assign s2_emit = (s2_op_ff != S2_LOAD_CHAN);
   assign s2_go   = s2_valid_ff && (!s2_emit || !out_full);
   assign step    = !cmd_empty && (!s2_valid_ff || s2_go);
   assign cmd_pop = step && (!cmd_data.is_payload || nib_sel_ff);

   assign cur_op  = nib_sel_ff ? cmd_data.op1 : cmd_data.op0;
   assign cur_end = nib_sel_ff ? cmd_data.end1 : cmd_data.end0;
   assign nib     = nib_sel_ff ? cmd_data.data[7:4] : cmd_data.data[3:0];
   assign res     = (cur_op == NIB_DIFF) ? adapt(diff_ff, diff_idx_ff, nib)
                                         : adapt(sum_ff, sum_idx_ff, nib);

   // Halving by a shift rounds down, so a negative sum is nudged up by one first to round toward zero.
   assign avg_sum = 17'(chan_ff) + 17'(s2_val_ff);
   assign avg_adj = avg_sum + (avg_sum[16] ? 17'sd1 : 17'sd0);
   assign avg     = avg_adj[16:1];

   always_comb begin
      sum_in      = sum_ff;
      diff_in     = diff_ff;
      sum_idx_in  = sum_idx_ff;
      diff_idx_in = diff_idx_ff;
      lo_in       = lo_ff;
      nib_sel_in  = nib_sel_ff;
      s2_valid_in = s2_valid_ff && !s2_go;
      s2_op_in    = s2_op_ff;
      s2_sum_in   = s2_sum_ff;
      s2_val_in   = s2_val_ff;
      s2_last_in  = s2_last_ff;
      if (step) begin
         if (!cmd_data.is_payload) begin
            unique case (cmd_data.pre_op)
               PRE_NONE: begin
               end
               PRE_LATCH_LO: lo_in = cmd_data.data;
               PRE_LOAD_SUM: sum_in = {cmd_data.data, lo_ff};
               PRE_LOAD_DIFF: begin
                  diff_in     = {cmd_data.data, lo_ff};
                  s2_valid_in = 1'b1;
                  s2_op_in    = S2_LOAD_CHAN;
                  s2_val_in   = {cmd_data.data, lo_ff};
               end
               PRE_LOAD_SIDX: sum_idx_in = clamp_index(cmd_data.data);
               PRE_LOAD_DIDX: diff_idx_in = clamp_index(cmd_data.data);
               default: begin
               end
            endcase
         end else begin
            nib_sel_in = !nib_sel_ff;
            unique case (cur_op)
               NIB_NONE: begin
               end
               NIB_SUM: begin
                  sum_in     = res.pred;
                  sum_idx_in = res.idx;
               end
               NIB_DIFF: begin
                  diff_in     = res.pred;
                  diff_idx_in = res.idx;
                  s2_valid_in = 1'b1;
                  s2_op_in    = S2_EMIT_DIFF;
                  s2_sum_in   = sum_ff;
                  s2_val_in   = res.pred;
                  s2_last_in  = 1'b0;
               end
               NIB_SUM_EMIT: begin
                  sum_in      = res.pred;
                  sum_idx_in  = res.idx;
                  s2_valid_in = 1'b1;
                  s2_op_in    = S2_EMIT_SUM;
                  s2_sum_in   = res.pred;
                  s2_last_in  = cur_end;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      chan_in       = chan_ff;
      out_push      = 1'b0;
      out_data.sum  = s2_sum_ff;
      out_data.chan = chan_ff;
      out_data.last = s2_last_ff;
      if (s2_go) begin
         unique case (s2_op_ff)
            S2_LOAD_CHAN: chan_in = s2_val_ff;
            S2_EMIT_DIFF: begin
               chan_in       = avg;
               out_push      = 1'b1;
               out_data.chan = avg;
            end
            S2_EMIT_SUM: out_push = 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         diff_ff     <= '0;
         sum_idx_ff  <= '0;
         diff_idx_ff <= '0;
         lo_ff       <= '0;
         nib_sel_ff  <= 1'b0;
         chan_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         diff_ff     <= diff_in;
         sum_idx_ff  <= sum_idx_in;
         diff_idx_ff <= diff_idx_in;
         lo_ff       <= lo_in;
         nib_sel_ff  <= nib_sel_in;
         chan_ff     <= chan_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff   <= s2_op_in;
      s2_sum_ff  <= s2_sum_in;
      s2_val_ff  <= s2_val_in;
      s2_last_ff <= s2_last_in;
   end

   `DK3_ASSERT_IMPL(idx_range_a, 1'b1, sum_idx_ff <= 7'(INDEX_MAX) && diff_idx_ff <= 7'(INDEX_MAX), "step index out of range")
   `DK3_ASSERT_NEXT(s2_hold_a, s2_valid_ff && !s2_go, s2_valid_ff && $stable(s2_op_ff), "stalled pair stage lost its item")
   `DK3_ASSERT_NEXT(nib_seq_a, step && cmd_data.is_payload && !nib_sel_ff, nib_sel_ff, "second nibble of a byte skipped")

endmodule

/* rtl/dk3_adpcm_stereo_decoder_unit.sv */
// Path of a byte, back end idle: command queue, predictor update per nibble (low nibble first),
// pair stage, result queue. Throughput: one nibble update and one preamble byte per cycle while
// the result queue has room; a payload byte needs two nibble updates, which limits payload input.
// Reset is synchronous and active high: block size returns to 1024, or to MAX_BLOCK_BYTES if
// that is smaller; predictors, indices and position clear to zero and both queues empty.
// No clearing pass is needed.
module dk3_adpcm_stereo_decoder_unit #(
   parameter int MAX_BLOCK_BYTES = dk3_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [dk3_pkg::CSR_W-1:0]  csr_wr_data,
   input  logic                       push,
   output logic                       full,
   input  logic [7:0]                 req_data_byte,
   output logic                       empty,
   input  logic                       pop,
   output logic signed [15:0]         rsp_left_sample,
   output logic signed [15:0]         rsp_right_sample,
   output logic                       rsp_block_end
);
   import dk3_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int OUT_W = $bits(pair_type);

   logic             accept;
   logic             cmd_push, cmd_pop, cmd_empty;
   cmd_type          cmd_wr, cmd_rd;
   logic [CMD_W-1:0] cmd_rd_bits;
   logic             out_push, out_full;
   pair_type         out_wr, out_rd;
   logic [OUT_W-1:0] out_rd_bits;

   assign accept = push && !full;
   assign cmd_rd = cmd_type'(cmd_rd_bits);
   assign out_rd = pair_type'(out_rd_bits);

   dk3_front #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_valid  (accept),
      .byte_data   (req_data_byte),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wr)
   );

   dk3_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_bits),
      .empty   (cmd_empty)
   );

   dk3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wr)
   );

   dk3_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rd_bits),
      .empty   (empty)
   );

   // Left and right are formed at the queue head; the sums wrap to 16 bits.
   assign rsp_left_sample  = out_rd.sum + out_rd.chan;
   assign rsp_right_sample = out_rd.sum - out_rd.chan;
   assign rsp_block_end    = out_rd.last;

endmodule
